// ===== src/crc8wfd_pkg.sv =====
`timescale 1ns / 1ps

package crc8wfd_pkg;

  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;

  localparam logic [1:0] MODE_RX_BYTE  = 2'd0;
  localparam logic [1:0] MODE_TX_ARG   = 2'd1;
  localparam logic [1:0] MODE_TX_CMD   = 2'd2;
  localparam logic [1:0] MODE_RX_START = 2'd3;

  localparam logic [1:0] KIND_TX_BYTE = 2'd0;
  localparam logic [1:0] KIND_RX_WORD = 2'd1;
  localparam logic [1:0] KIND_RX_PAIR = 2'd2;
  localparam logic [1:0] KIND_CRC_ERR = 2'd3;

  typedef logic [1:0] kind_t;
  typedef logic [7:0] byte_t;

  // CRC-8, MSB first, over the high byte then the low byte; pure XOR network
  function automatic byte_t crc8_word(input byte_t hi, input byte_t lo);
    byte_t c;
    c = CrcInit ^ hi;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    c = c ^ lo;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== src/crc8_word_framer_deframer_core.sv =====
`timescale 1ns / 1ps

// CRC-8 word framer / deframer.
// Input channel (in_valid/in_ready): one item per handshake. Mode selects a
// received byte, an argument word to send (hi, lo, CRC), a command word to send
// (hi, lo) or a receive frame start.
// Result channel (out_valid/out_ready): one result per handshake; out_last flags
// the final result of an input item.
// Latency: results of an item appear on the cycle after it is accepted, from a
// result register loaded at accept time.
// Throughput: received bytes and frame starts run at one item per cycle while
// the receiver takes results. A command word holds the result register for two
// results and an argument word for three, one per transmitted byte; the next item
// is taken in the cycle its last result leaves.
// Reset (rst_n low, synchronous): receive group, pair and failure state clear,
// result register empties.
// Receiver stall: the pending result holds; in_ready stays low until the last
// result of that item is taken, and items that make no result wait as well.
module crc8_word_framer_deframer_core
  import crc8wfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_data_in,
  input  logic        in_ends_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_out_byte,
  output logic [15:0] out_out_word,
  output logic [31:0] out_pair_value,
  output logic        out_frame_end,
  output logic        out_last
);

  // receive state
  logic [1:0]  pos_r, pos_nxt;
  byte_t       first_r, first_nxt;
  byte_t       second_r, second_nxt;
  logic [15:0] held_r, held_nxt;
  logic        parity_r, parity_nxt;
  logic        failed_r, failed_nxt;

  // result register
  logic        busy_r, busy_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [1:0]  last_idx_r, last_idx_nxt;
  kind_t       kind_r, kind_nxt;
  byte_t       b0_r, b0_nxt, b1_r, b1_nxt, b2_r, b2_nxt;
  logic [15:0] word_r, word_nxt;
  logic [31:0] pair_r, pair_nxt;
  logic        fend_r, fend_nxt;

  logic        in_acc, out_acc, at_last, load;
  byte_t       rx_b, tx_crc, rx_crc;
  logic [15:0] rx_word;

  assign at_last  = (idx_r == last_idx_r);
  assign in_ready = !busy_r || (out_ready && at_last);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = busy_r && out_ready;

  assign rx_b    = in_data_in[7:0];
  assign rx_word = {first_r, second_r};
  assign tx_crc  = crc8_word(in_data_in[15:8], in_data_in[7:0]);
  assign rx_crc  = crc8_word(first_r, second_r);

  always_comb begin
    pos_nxt      = pos_r;
    first_nxt    = first_r;
    second_nxt   = second_r;
    held_nxt     = held_r;
    parity_nxt   = parity_r;
    failed_nxt   = failed_r;
    load         = 1'b0;
    last_idx_nxt = last_idx_r;
    kind_nxt     = kind_r;
    b0_nxt       = b0_r;
    b1_nxt       = b1_r;
    b2_nxt       = b2_r;
    word_nxt     = word_r;
    pair_nxt     = pair_r;
    fend_nxt     = fend_r;

    if (in_acc) begin
      fend_nxt = in_ends_frame;
      unique case (in_mode) inside
        MODE_RX_START: begin
          pos_nxt    = 2'd0;
          parity_nxt = 1'b0;
          failed_nxt = 1'b0;
        end
        MODE_TX_CMD, MODE_TX_ARG: begin
          load         = 1'b1;
          kind_nxt     = KIND_TX_BYTE;
          b0_nxt       = in_data_in[15:8];
          b1_nxt       = in_data_in[7:0];
          b2_nxt       = tx_crc;
          word_nxt     = '0;
          pair_nxt     = '0;
          last_idx_nxt = (in_mode == MODE_TX_ARG) ? 2'd2 : 2'd1;
        end
        default: begin
          if (!failed_r) begin
            if (pos_r == 2'd0) begin
              first_nxt = rx_b;
              pos_nxt   = 2'd1;
            end else if (pos_r == 2'd1) begin
              second_nxt = rx_b;
              pos_nxt    = 2'd2;
            end else begin
              // third byte of the group carries the CRC
              pos_nxt      = 2'd0;
              load         = 1'b1;
              last_idx_nxt = 2'd0;
              b0_nxt       = '0;
              word_nxt     = rx_word;
              pair_nxt     = '0;
              if (rx_crc != rx_b) begin
                failed_nxt = 1'b1;
                kind_nxt   = KIND_CRC_ERR;
              end else if (!parity_r) begin
                held_nxt   = rx_word;
                parity_nxt = 1'b1;
                kind_nxt   = KIND_RX_WORD;
              end else begin
                parity_nxt = 1'b0;
                kind_nxt   = KIND_RX_PAIR;
                pair_nxt   = {held_r, rx_word};
              end
            end
          end
          if (in_ends_frame) begin
            pos_nxt    = 2'd0;
            parity_nxt = 1'b0;
            failed_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (out_acc) begin
      if (at_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 2'd0;
      first_r  <= '0;
      second_r <= '0;
      held_r   <= '0;
      parity_r <= 1'b0;
      failed_r <= 1'b0;
      busy_r   <= 1'b0;
      idx_r    <= 2'd0;
    end else begin
      pos_r    <= pos_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      held_r   <= held_nxt;
      parity_r <= parity_nxt;
      failed_r <= failed_nxt;
      busy_r   <= busy_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_idx_r <= last_idx_nxt;
    kind_r     <= kind_nxt;
    b0_r       <= b0_nxt;
    b1_r       <= b1_nxt;
    b2_r       <= b2_nxt;
    word_r     <= word_nxt;
    pair_r     <= pair_nxt;
    fend_r     <= fend_nxt;
  end

  always_comb begin
    case (idx_r)
      2'd0:    out_out_byte = b0_r;
      2'd1:    out_out_byte = b1_r;
      default: out_out_byte = b2_r;
    endcase
  end

  assign out_valid      = busy_r;
  assign out_kind       = kind_r;
  assign out_out_word   = word_r;
  assign out_pair_value = pair_r;
  assign out_frame_end  = fend_r;
  assign out_last       = at_last;

endmodule

// ===== sim/crc8_word_framer_deframer_core_tb.sv =====
`timescale 1ns / 1ps

module crc8_word_framer_deframer_core_tb;
  import crc8wfd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] data;
    logic        fend;
  } codec_item_t;

  typedef struct packed {
    kind_t       kind;
    byte_t       tx_byte;
    logic [15:0] word;
    logic [31:0] pair;
    logic        frame_end;
    logic        last;
  } codec_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_RX_START;
  logic [15:0] in_data_in = 16'h0000;
  logic        in_ends_frame = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_out_byte;
  logic [15:0] out_out_word;
  logic [31:0] out_pair_value;
  logic        out_frame_end;
  logic        out_last;

  codec_item_t   pending[$];
  codec_result_t due_results[$];
  codec_item_t   next_item;
  codec_result_t want;

  // receive-side state of the predictor
  logic [1:0]  rx_slot;
  logic [7:0]  rx_hi;
  logic [7:0]  rx_lo;
  logic [15:0] pair_hold;
  logic        pair_waiting;
  logic        frame_dead;

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  src_gap = 0;
  int  ready_gap = 0;
  bit  idle_on = 1'b1;
  bit  long_hold_req = 1'b0;
  bit  long_hold_done = 1'b0;

  crc8_word_framer_deframer_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_data_in    (in_data_in),
    .in_ends_frame (in_ends_frame),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_out_byte  (out_out_byte),
    .out_out_word  (out_out_word),
    .out_pair_value(out_pair_value),
    .out_frame_end (out_frame_end),
    .out_last      (out_last)
  );

  always #1 clk = ~clk;

  // bitwise MSB-first CRC-8 over hi then lo
  function automatic logic [7:0] crc8_over_word(logic [7:0] hi, logic [7:0] lo);
    logic [15:0] bits;
    logic [7:0]  c;
    bits = {hi, lo};
    c = CrcInit;
    for (int i = 15; i >= 0; i--) begin
      if (c[7] ^ bits[i]) c = {c[6:0], 1'b0} ^ CrcPoly;
      else c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  task automatic queue_result(kind_t kind, byte_t b, logic [15:0] w, logic [31:0] p,
                              logic fend, logic lst);
    codec_result_t r;
    r.kind = kind;
    r.tx_byte = b;
    r.word = w;
    r.pair = p;
    r.frame_end = fend;
    r.last = lst;
    due_results.push_back(r);
  endtask

  task automatic codec_step(logic [1:0] mode, logic [15:0] data, logic fend);
    logic [7:0]  b;
    logic [15:0] w;
    b = data[7:0];
    case (mode)
      MODE_RX_START: begin
        rx_slot = 2'd0;
        pair_waiting = 1'b0;
        frame_dead = 1'b0;
      end
      MODE_TX_CMD: begin
        queue_result(KIND_TX_BYTE, data[15:8], 16'h0, 32'h0, fend, 1'b0);
        queue_result(KIND_TX_BYTE, data[7:0], 16'h0, 32'h0, fend, 1'b1);
      end
      MODE_TX_ARG: begin
        queue_result(KIND_TX_BYTE, data[15:8], 16'h0, 32'h0, fend, 1'b0);
        queue_result(KIND_TX_BYTE, data[7:0], 16'h0, 32'h0, fend, 1'b0);
        queue_result(KIND_TX_BYTE, crc8_over_word(data[15:8], data[7:0]), 16'h0, 32'h0,
                     fend, 1'b1);
      end
      MODE_RX_BYTE: begin
        if (!frame_dead) begin
          if (rx_slot == 2'd0) begin
            rx_hi = b;
            rx_slot = 2'd1;
          end else if (rx_slot == 2'd1) begin
            rx_lo = b;
            rx_slot = 2'd2;
          end else begin
            w = {rx_hi, rx_lo};
            rx_slot = 2'd0;
            if (crc8_over_word(rx_hi, rx_lo) != b) begin
              frame_dead = 1'b1;
              queue_result(KIND_CRC_ERR, 8'h0, w, 32'h0, fend, 1'b1);
            end else if (!pair_waiting) begin
              pair_hold = w;
              pair_waiting = 1'b1;
              queue_result(KIND_RX_WORD, 8'h0, w, 32'h0, fend, 1'b1);
            end else begin
              pair_waiting = 1'b0;
              queue_result(KIND_RX_PAIR, 8'h0, w, {pair_hold, w}, fend, 1'b1);
            end
          end
        end
        if (fend) begin
          rx_slot = 2'd0;
          pair_waiting = 1'b0;
          frame_dead = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(string what);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  task automatic push_item(logic [1:0] mode, logic [15:0] data, logic fend);
    codec_item_t it;
    it.mode = mode;
    it.data = data;
    it.fend = fend;
    pending.push_back(it);
  endtask

  // upper bits of a received byte item are junk on purpose
  task automatic push_rx_byte(logic [7:0] b, logic fend);
    push_item(MODE_RX_BYTE, {8'($urandom), b}, fend);
  endtask

  task automatic push_rx_word(logic [15:0] word, bit bad, logic fend);
    logic [7:0] chk;
    chk = crc8_over_word(word[15:8], word[7:0]);
    if (bad) chk = chk ^ 8'($urandom_range(1, 255));
    push_rx_byte(word[15:8], 1'b0);
    push_rx_byte(word[7:0], 1'b0);
    push_rx_byte(chk, fend);
  endtask

  task automatic push_tx_word();
    push_item($urandom_range(0, 1) ? MODE_TX_ARG : MODE_TX_CMD, 16'($urandom),
              1'($urandom));
  endtask

  task automatic push_rx_frame();
    int nwords;
    bit cut;
    nwords = $urandom_range(1, 4);
    cut = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 3) != 0) push_item(MODE_RX_START, 16'($urandom), 1'($urandom));
    for (int w = 0; w < nwords; w++) begin
      if ($urandom_range(0, 9) == 0) push_tx_word();
      push_rx_word(16'($urandom), $urandom_range(0, 11) == 0, !cut && w == nwords - 1);
    end
    if (cut) begin
      if ($urandom_range(0, 1)) push_rx_byte(8'($urandom), 1'b0);
      push_rx_byte(8'($urandom), 1'b1);
    end
  endtask

  task automatic push_random_chunk();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) push_rx_frame();
    else if (pick < 17) push_tx_word();
    else push_item(2'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic wait_for_quiet();
    while (pending.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap <= 0;
      rx_slot = 2'd0;
      rx_hi = 8'h0;
      rx_lo = 8'h0;
      pair_hold = 16'h0;
      pair_waiting = 1'b0;
      frame_dead = 1'b0;
    end else begin
      if (in_valid && in_ready) codec_step(in_mode, in_data_in, in_ends_frame);
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          src_gap <= $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          next_item = pending.pop_front();
          in_mode <= next_item.mode;
          in_data_in <= next_item.data;
          in_ends_frame <= next_item.fend;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind %0d", out_kind));
        end else begin
          want = due_results.pop_front();
          if (out_kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
          if (out_out_byte !== want.tx_byte)
            flag_mismatch($sformatf("byte %h, want %h", out_out_byte, want.tx_byte));
          if (out_out_word !== want.word)
            flag_mismatch($sformatf("word %h, want %h", out_out_word, want.word));
          if (out_pair_value !== want.pair)
            flag_mismatch($sformatf("pair %h, want %h", out_pair_value, want.pair));
          if (out_frame_end !== want.frame_end)
            flag_mismatch($sformatf("frame_end %b, want %b", out_frame_end, want.frame_end));
          if (out_last !== want.last)
            flag_mismatch($sformatf("last %b, want %b", out_last, want.last));
        end
      end
      if (ready_gap > 0) begin
        ready_gap <= ready_gap - 1;
        out_ready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
        ready_gap <= LONG_HOLD;
        long_hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        ready_gap <= $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("crc8_word_framer_deframer_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_item(MODE_TX_CMD, 16'h0000, 1'b0);
    push_item(MODE_TX_CMD, 16'hFFFF, 1'b1);
    push_item(MODE_TX_ARG, 16'hBEEF, 1'b0);
    push_item(MODE_TX_ARG, 16'h0000, 1'b0);
    push_item(MODE_TX_ARG, 16'hFFFF, 1'b1);
    push_item(MODE_RX_START, 16'hFFFF, 1'b0);
    push_rx_word(16'h0000, 1'b0, 1'b0);
    push_item(MODE_TX_ARG, 16'h1234, 1'b0);     // tx mid-frame, rx state untouched
    push_rx_word(16'hFFFF, 1'b0, 1'b1);         // completes the pair
    push_rx_byte(8'hFF, 1'b0);                  // partial group dropped at end
    push_rx_byte(8'h00, 1'b1);
    push_item(MODE_RX_START, 16'h0000, 1'b1);   // ends_frame ignored on start
    push_rx_word(16'hBEEF, 1'b0, 1'b1);         // lone word, no partner
    push_rx_word(16'hA5A5, 1'b1, 1'b0);         // bad CRC kills the frame
    push_rx_byte(8'h5A, 1'b0);
    push_rx_byte(8'hC3, 1'b1);
    wait_for_quiet();

    while (pending.size() < 150) push_random_chunk();
    // receiver stalls long while the sender keeps offering
    long_hold_req = 1'b1;
    wait_for_quiet();

    while (pending.size() < 130) push_random_chunk();
    wait_for_quiet();

    idle_on = 1'b0;
    while (pending.size() < 50) push_random_chunk();
    wait_for_quiet();
    repeat (8) @(negedge clk);

    if (mismatch_count == 0 && due_results.size() == 0)
      $display("crc8_word_framer_deframer_core_tb OK");
    else
      $display("crc8_word_framer_deframer_core_tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
src/crc8wfd_pkg.sv
src/crc8_word_framer_deframer_core.sv
sim/crc8_word_framer_deframer_core_tb.sv
